// ----- src/dwg_pkg.sv -----
// Shared types, command codes and colour ramp for the damped wave grid engine.
`timescale 1ns / 1ps
package dwg_pkg;
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INJECT = 2'd1,
    CMD_STEP   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  localparam int unsigned SHAPE_WIDE = 100;
  localparam int unsigned SHAPE_PLUS = 50;

  function automatic logic [15:0] ramp_colour(input logic [7:0] i);
    logic [8:0] k;
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    logic [15:0] t6, t28, t18, t21, t23, t2;
    k = 9'({1'b0, i}) - 9'd127;
    t6  = 16'(i) * 16'd6;
    t28 = 16'(i) * 16'd28;
    t18 = 16'(i) * 16'd18;
    t21 = 16'(k) * 16'd21;
    t23 = 16'(k) * 16'd23;
    t2  = 16'(k) * 16'd2;
    if (!i[7]) begin
      r = 5'(5'd4 + 5'(t6 >> 7));
      g = 6'(6'd12 + 6'(t28 >> 7));
      b = 5'(5'd11 + 5'(t18 >> 7));
    end else begin
      r = 5'(5'd10 + 5'(t21 >> 7));
      g = 6'(6'd40 + 6'(t23 >> 7));
      b = 5'(5'd29 + 5'(t2 >> 7));
    end
    return {r, g, b};
  endfunction
endpackage

// ----- src/damped_wave_grid_engine_top.sv -----
// Top level of the damped wave grid engine: sequencer over three plane memories.
`timescale 1ns / 1ps
// Damped 2-D ripple engine.
// Input channel (cmd_i, row_i, column_i, amplitude_i, damping_i) with valid/stall;
// one result per item (status_o, cell_value_o, cell_colour_o) on an output
// channel with valid/stall. Items are handled one at a time by a sequencer;
// each cycle it does one memory access per plane memory (one cell read or write).
// Work done per item between the input transfer and a valid result:
//  - clear: walks all cells of all three planes.
//  - inject: nine write slots, unused ones write nothing.
//    A position off the interior sets the status bit and writes nothing.
//  - step: per interior cell, 4 reads of the current plane (one per cycle)
//    overlapping with the previous-plane read, a multiply, then a write;
//    the single read port of the current plane sets the pace of a step.
//  - read: a registered plane read; a cell off the grid sets the status bit.
// The result sits in an output register; the input stays stalled until it is
// transferred. A stalled result holds. After reset the planes are zero: a
// clearing pass over all ROWS*COLS cells runs first and no item is taken meanwhile.
// Rotation resets to zero. Boundary cells are never written by a step.
module damped_wave_grid_engine_top #(
  parameter int unsigned GRID_ROWS = 120,
  parameter int unsigned GRID_COLS = 160,
  parameter int unsigned AMPLITUDE_SCALE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  row_i,
  input  logic [7:0]  column_i,
  input  logic signed [7:0] amplitude_i,
  input  logic [8:0]  damping_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic signed [15:0] cell_value_o,
  output logic [15:0] cell_colour_o
);
  import dwg_pkg::*;

  localparam int unsigned Cells = GRID_ROWS * GRID_COLS;
  localparam int unsigned AW = $clog2(Cells);
  localparam int unsigned RW = $clog2(GRID_ROWS);
  localparam int unsigned CW = $clog2(GRID_COLS);
  // reciprocal of the scale, exact floor division for 16-bit magnitudes
  localparam int unsigned RecipShift = 23;
  localparam longint unsigned Recip =
    ((64'd1 << RecipShift) + AMPLITUDE_SCALE - 1) / AMPLITUDE_SCALE;

  typedef enum logic [8:0] {
    S_WIPE  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_INJ   = 9'b000000100,
    S_STR   = 9'b000001000,
    S_STW   = 9'b000010000,
    S_RDA   = 9'b000100000,
    S_RDB   = 9'b001000000,
    S_RDC   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] rot_q, rot_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [RW-1:0] r_q, r_d;
  logic [CW-1:0] c_q, c_d;
  logic [3:0] ph_q, ph_d;
  logic signed [15:0] sfull_q, shalf_q, squart_q;
  logic [1:0] shape_q;
  logic [8:0] damp_q;
  logic signed [17:0] acc_q, acc_d;
  logic signed [15:0] prv_q, prv_d;
  logic ov_q, ov_d, st_q, st_d;
  logic signed [15:0] val_q, val_d;
  logic [15:0] col_q, col_d;
  logic signed [26:0] prod_q, prod_d;

  logic [2:0] we;
  logic [AW-1:0] addr [3];
  logic [15:0] wdata;
  logic [15:0] rdata [3];

  for (genvar p = 0; p < 3; p++) begin : g_plane
    dwg_ram #(.Width(16), .Depth(Cells)) u_ram (
      .clk_i, .we_i(we[p]), .addr_i(addr[p]), .wdata_i(wdata), .rdata_o(rdata[p]));
  end

  logic [1:0] pcur, pnxt, pprv;
  assign pcur = rot_q;
  assign pnxt = (rot_q == 2'd2) ? 2'd0 : rot_q + 2'd1;
  assign pprv = (rot_q == 2'd0) ? 2'd2 : rot_q - 2'd1;

  function automatic logic [AW-1:0] cell_addr(input logic [RW:0] r, input logic [CW:0] c);
    return AW'(32'(r) * GRID_COLS + 32'(c));
  endfunction

  // input waits while busy or while a result is still unsent
  assign in_stall_o = !(state_q == S_IDLE) || ov_q;
  assign out_valid_o = ov_q;
  assign status_o = st_q;
  assign cell_value_o = val_q;
  assign cell_colour_o = col_q;

  logic accept;
  assign accept = in_valid_i && !in_stall_o;

  // inject offsets by phase 0..8
  logic signed [1:0] dr, dc;
  logic [15:0] injv;
  logic inj_use;
  always_comb begin
    dr = 2'sd0; dc = 2'sd0; injv = sfull_q; inj_use = 1'b1;
    unique case (ph_q)
      4'd0: begin end
      4'd1: begin dr = -2'sd1; injv = shalf_q; inj_use = shape_q != 2'd0; end
      4'd2: begin dr = 2'sd1; injv = shalf_q; inj_use = shape_q != 2'd0; end
      4'd3: begin dc = -2'sd1; injv = shalf_q; inj_use = shape_q != 2'd0; end
      4'd4: begin dc = 2'sd1; injv = shalf_q; inj_use = shape_q != 2'd0; end
      4'd5: begin dr = -2'sd1; dc = -2'sd1; injv = squart_q; inj_use = shape_q == 2'd2; end
      4'd6: begin dr = -2'sd1; dc = 2'sd1; injv = squart_q; inj_use = shape_q == 2'd2; end
      4'd7: begin dr = 2'sd1; dc = -2'sd1; injv = squart_q; inj_use = shape_q == 2'd2; end
      4'd8: begin dr = 2'sd1; dc = 2'sd1; injv = squart_q; inj_use = shape_q == 2'd2; end
      default: inj_use = 1'b0;
    endcase
  end

  // stencil neighbour for phase 0..3
  logic [RW:0] nr;
  logic [CW:0] nc;
  always_comb begin
    nr = {1'b0, r_q}; nc = {1'b0, c_q};
    unique case (ph_q[1:0])
      2'd0: nr = {1'b0, r_q} - 1'b1;
      2'd1: nr = {1'b0, r_q} + 1'b1;
      2'd2: nc = {1'b0, c_q} - 1'b1;
      2'd3: nc = {1'b0, c_q} + 1'b1;
    endcase
  end

  logic signed [16:0] halfsum;
  logic signed [17:0] ndiff;
  assign halfsum = 17'(acc_q >>> 1);
  assign ndiff = 18'(halfsum) - 18'(prv_q);

  // colour index: value over scale, truncated toward zero
  logic signed [15:0] rv;
  logic [15:0] rv_mag;
  logic [39:0] qprod;
  logic [15:0] q_mag;
  logic signed [15:0] q;
  logic signed [16:0] idx;
  assign rv = rdata[pcur];
  assign rv_mag = rv[15] ? 16'(-rv) : 16'(rv);
  assign qprod = 40'(rv_mag) * 40'(Recip);
  assign q_mag = 16'(qprod >> RecipShift);
  assign q = rv[15] ? -$signed(q_mag) : $signed(q_mag);
  assign idx = 17'(q) + 17'sd128;

  logic signed [15:0] s_in;
  assign s_in = 16'(amplitude_i) * $signed(16'(AMPLITUDE_SCALE));

  always_comb begin
    state_d = state_q; rot_d = rot_q; cnt_d = cnt_q; r_d = r_q; c_d = c_q; ph_d = ph_q;
    acc_d = acc_q; prv_d = prv_q; ov_d = ov_q; st_d = st_q; val_d = val_q; col_d = col_q;
    prod_d = prod_q;
    we = '0; wdata = '0;
    for (int p = 0; p < 3; p++) addr[p] = cnt_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    unique case (state_q)
      S_WIPE: begin
        we = 3'b111;
        cnt_d = cnt_q + 1'b1;
        if (32'(cnt_q) == Cells - 1) state_d = S_DONE;
      end
      S_IDLE: begin
        ph_d = '0; cnt_d = '0;
        r_d = RW'(row_i); c_d = CW'(column_i);
        if (accept) begin
          st_d = 1'b0; val_d = '0; col_d = '0;
          unique case (cmd_e'(cmd_i))
            CMD_CLEAR: state_d = S_WIPE;
            CMD_INJECT: begin
              if (row_i >= 8'd1 && 32'(row_i) + 1 < GRID_ROWS &&
                  column_i >= 8'd1 && 32'(column_i) + 1 < GRID_COLS)
                state_d = S_INJ;
              else begin st_d = 1'b1; state_d = S_DONE; end
            end
            CMD_STEP: begin
              r_d = RW'(1); c_d = CW'(1); acc_d = '0; state_d = S_STR;
            end
            CMD_READ: begin
              if (32'(row_i) < GRID_ROWS && 32'(column_i) < GRID_COLS) state_d = S_RDA;
              else begin st_d = 1'b1; state_d = S_DONE; end
            end
          endcase
        end
      end
      S_INJ: begin
        addr[pcur] = cell_addr((RW+1)'(signed'({1'b0, r_q}) + dr),
                               (CW+1)'(signed'({1'b0, c_q}) + dc));
        wdata = injv;
        we[pcur] = inj_use;
        ph_d = ph_q + 1'b1;
        if (ph_q == 4'd8) state_d = S_DONE;
      end
      S_STR: begin
        // phases 0..3 read neighbours, 4 takes prev data; reads are registered
        if (ph_q <= 4'd3) addr[pcur] = cell_addr(nr, nc);
        addr[pprv] = cell_addr({1'b0, r_q}, {1'b0, c_q});
        if (ph_q >= 4'd1 && ph_q <= 4'd4)
          acc_d = (ph_q == 4'd1 ? 18'sd0 : acc_q) + 18'(signed'(rdata[pcur]));
        if (ph_q == 4'd4) prv_d = rdata[pprv];
        if (ph_q == 4'd5) prod_d = 27'(ndiff) * 27'(signed'({1'b0, damp_q}));
        ph_d = ph_q + 1'b1;
        if (ph_q == 4'd5) state_d = S_STW;
      end
      S_STW: begin
        addr[pnxt] = cell_addr({1'b0, r_q}, {1'b0, c_q});
        wdata = 16'(prod_q >>> 8);
        we[pnxt] = 1'b1;
        ph_d = '0;
        state_d = S_STR;
        if (32'(c_q) + 2 >= GRID_COLS) begin
          c_d = CW'(1);
          r_d = r_q + 1'b1;
          if (32'(r_q) + 2 >= GRID_ROWS) begin
            rot_d = pnxt; state_d = S_DONE;
          end
        end else c_d = c_q + 1'b1;
      end
      S_RDA: begin
        addr[pcur] = cell_addr({1'b0, r_q}, {1'b0, c_q});
        state_d = S_RDB;
      end
      S_RDB: begin
        val_d = rv;
        col_d = ramp_colour(idx < 0 ? 8'd0 : (idx > 17'sd255 ? 8'd255 : 8'(idx)));
        state_d = S_DONE;
      end
      S_RDC: state_d = S_DONE;
      S_DONE: begin
        ov_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // the power-up wipe ends without a result
  logic boot_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_WIPE; rot_q <= '0; cnt_q <= '0; ph_q <= '0; ov_q <= 1'b0;
      boot_q <= 1'b1;
    end else begin
      state_q <= state_d; rot_q <= rot_d; cnt_q <= cnt_d; ph_q <= ph_d;
      ov_q <= (state_q == S_DONE && boot_q) ? 1'b0 : ov_d;
      if (state_q == S_DONE) boot_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d; c_q <= c_d; acc_q <= acc_d; prv_q <= prv_d; st_q <= st_d;
    val_q <= val_d; col_q <= col_d; prod_q <= prod_d;
    if (accept) begin
      damp_q <= damping_i;
      sfull_q <= s_in;
      shalf_q <= s_in >>> 1;
      squart_q <= s_in >>> 2;
      shape_q <= (amplitude_i <= -8'sd100 || amplitude_i >= 8'sd100) ? 2'd2 :
                 (amplitude_i <= -8'sd50 || amplitude_i >= 8'sd50) ? 2'd1 : 2'd0;
    end
  end
endmodule

// ----- src/dwg_ram.sv -----
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module dwg_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for damped_wave_grid_engine_top with its own plane predictor.
`timescale 1ns / 1ps
module tb_top;
  import dwg_pkg::*;

  localparam int unsigned ROWS  = 120;
  localparam int unsigned COLS  = 160;
  localparam int unsigned SCALE = 16;
  localparam int unsigned CELLS = ROWS * COLS;
  // a step visits every interior cell; allow many times the slowest run
  localparam longint unsigned CYCLE_LIMIT = 40_000_000;
  localparam int unsigned HOLD_CYCLES = 600;

  typedef struct {
    cmd_e              cmd;
    logic [7:0]        row;
    logic [7:0]        column;
    logic signed [7:0] amplitude;
    logic [8:0]        damping;
  } wave_cmd_t;

  typedef struct {
    logic               status;
    logic signed [15:0] value;
    logic [15:0]        colour;
  } cell_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] cmd_drv = CMD_CLEAR;
  logic [7:0] row_drv = '0;
  logic [7:0] column_drv = '0;
  logic signed [7:0] amplitude_drv = '0;
  logic [8:0] damping_drv = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic status;
  logic signed [15:0] cell_value;
  logic [15:0] cell_colour;

  always #5 clk_i = ~clk_i;

  damped_wave_grid_engine_top #(
    .GRID_ROWS(ROWS), .GRID_COLS(COLS), .AMPLITUDE_SCALE(SCALE)
  ) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cmd_i(cmd_drv), .row_i(row_drv), .column_i(column_drv),
    .amplitude_i(amplitude_drv), .damping_i(damping_drv),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .cell_value_o(cell_value), .cell_colour_o(cell_colour)
  );

  wave_cmd_t    pending_cmds[$];
  cell_result_t expected_cells[$];
  wave_cmd_t    cur_cmd;
  int unsigned  cmds_taken = 0;
  int unsigned  mismatches = 0;

  // shadow of the three rotating planes
  logic [15:0] shadow_plane[3][CELLS];
  int unsigned rot = 0;

  // idle phase follows progress: none, sender idle, receiver stall, both
  function automatic int unsigned idle_pct(input bit sender);
    case ((cmds_taken / 25) % 4)
      0: return 0;
      1: return sender ? 84 : 0;
      2: return sender ? 0 : 84;
      default: return 27;
    endcase
  endfunction

  function automatic logic [15:0] ramp_lookup(input int i);
    int r, g, b, k;
    if (i < 128) begin
      r = 4 + ((i * 6) >> 7);
      g = 12 + ((i * 28) >> 7);
      b = 11 + ((i * 18) >> 7);
    end else begin
      k = i - 127;
      r = 10 + ((k * 21) >> 7);
      g = 40 + ((k * 23) >> 7);
      b = 29 + ((k * 2) >> 7);
    end
    return 16'((r << 11) | (g << 5) | b);
  endfunction

  function automatic int cell_at(input int r, input int c);
    return r * COLS + c;
  endfunction

  // stamp a source into the current plane
  task automatic stamp_source(input int r, input int c, input int amp);
    longint s;
    logic [15:0] full, half, quarter;
    bit wide, plus;
    s = longint'(amp) * SCALE;
    full = 16'(s);
    half = 16'(s >>> 1);
    quarter = 16'(s >>> 2);
    wide = (amp <= -100 || amp >= 100);
    plus = wide || amp <= -50 || amp >= 50;
    shadow_plane[rot][cell_at(r, c)] = full;
    if (plus) begin
      shadow_plane[rot][cell_at(r - 1, c)] = half;
      shadow_plane[rot][cell_at(r + 1, c)] = half;
      shadow_plane[rot][cell_at(r, c - 1)] = half;
      shadow_plane[rot][cell_at(r, c + 1)] = half;
    end
    if (wide) begin
      shadow_plane[rot][cell_at(r - 1, c - 1)] = quarter;
      shadow_plane[rot][cell_at(r - 1, c + 1)] = quarter;
      shadow_plane[rot][cell_at(r + 1, c - 1)] = quarter;
      shadow_plane[rot][cell_at(r + 1, c + 1)] = quarter;
    end
  endtask

  // damped stencil over the interior into the next plane, then rotate
  task automatic advance_wave(input int damp);
    int nxt, prv;
    longint sum, n;
    nxt = (rot + 1) % 3;
    prv = (rot + 2) % 3;
    for (int r = 1; r < ROWS - 1; r++) begin
      for (int c = 1; c < COLS - 1; c++) begin
        sum = longint'($signed(shadow_plane[rot][cell_at(r - 1, c)]))
            + longint'($signed(shadow_plane[rot][cell_at(r + 1, c)]))
            + longint'($signed(shadow_plane[rot][cell_at(r, c - 1)]))
            + longint'($signed(shadow_plane[rot][cell_at(r, c + 1)]));
        n = (sum >>> 1) - longint'($signed(shadow_plane[prv][cell_at(r, c)]));
        n = (n * damp) >>> 8;
        shadow_plane[nxt][cell_at(r, c)] = 16'(n);
      end
    end
    rot = nxt;
  endtask

  // apply one transfer to the shadow planes and queue its result
  task automatic predict_cell_result(input wave_cmd_t w);
    cell_result_t res;
    int q, idx;
    res = '{status: 1'b0, value: '0, colour: '0};
    case (w.cmd)
      CMD_CLEAR: begin
        foreach (shadow_plane[p, i]) shadow_plane[p][i] = '0;
      end
      CMD_INJECT: begin
        if (w.row >= 1 && w.row <= ROWS - 2 && w.column >= 1 && w.column <= COLS - 2)
          stamp_source(w.row, w.column, int'(w.amplitude));
        else
          res.status = 1'b1;
      end
      CMD_STEP: advance_wave(int'(w.damping));
      default: begin
        if (w.row < ROWS && w.column < COLS) begin
          res.value = shadow_plane[rot][cell_at(w.row, w.column)];
          q = int'(res.value) / int'(SCALE);  // truncates toward zero
          idx = q + 128;
          if (idx < 0) idx = 0;
          if (idx > 255) idx = 255;
          res.colour = ramp_lookup(idx);
        end else begin
          res.status = 1'b1;
        end
      end
    endcase
    expected_cells.push_back(res);
  endtask

  // driver: new transfer offered only once the current one is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_cell_result(cur_cmd);
        cmds_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          cur_cmd = pending_cmds.pop_front();
          cmd_drv <= cur_cmd.cmd;
          row_drv <= cur_cmd.row;
          column_drv <= cur_cmd.column;
          amplitude_drv <= cur_cmd.amplitude;
          damping_drv <= cur_cmd.damping;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off once, so the block backs up and stalls its input
  int unsigned hold_count = 0;
  logic hold_on;
  assign hold_on = (cmds_taken >= 45) && (hold_count < HOLD_CYCLES);
  always @(posedge clk_i) begin
    if (hold_on) hold_count <= hold_count + 1;
  end

  // monitor: compare each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    cell_result_t exp_res;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (expected_cells.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d value %0d colour %h",
                     status, cell_value, cell_colour);
        end else begin
          exp_res = expected_cells.pop_front();
          if (status !== exp_res.status || cell_value !== exp_res.value ||
              cell_colour !== exp_res.colour) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp status %0d value %0d colour %h, got %0d %0d %h",
                       exp_res.status, exp_res.value, exp_res.colour,
                       status, cell_value, cell_colour);
          end
        end
      end
      out_stall <= hold_on || ($urandom_range(99) < idle_pct(1'b0));
    end
  end

  longint unsigned cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("damped_wave_grid_engine_top regression: fail");
      $finish;
    end
  end

  function automatic wave_cmd_t mk_cmd(input cmd_e c, input int r, input int col,
                                       input int amp, input int damp);
    wave_cmd_t w;
    w.cmd = c;
    w.row = 8'(r);
    w.column = 8'(col);
    w.amplitude = 8'(amp);
    w.damping = 9'(damp);
    return w;
  endfunction

  initial begin
    int r0, c0, pick;
    int hot_r = 60, hot_c = 80;
    // directed: shape thresholds, interior corners, off-interior, damping extremes
    pending_cmds.push_back(mk_cmd(CMD_READ, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(CMD_INJECT, 1, 1, 127, 0));
    pending_cmds.push_back(mk_cmd(CMD_INJECT, 118, 158, -128, 511));
    pending_cmds.push_back(mk_cmd(CMD_INJECT, 60, 80, 100, 0));
    pending_cmds.push_back(mk_cmd(CMD_INJECT, 30, 40, -100, 0));
    pending_cmds.push_back(mk_cmd(CMD_INJECT, 60, 90, 50, 0));
    pending_cmds.push_back(mk_cmd(CMD_INJECT, 90, 30, -50, 0));
    pending_cmds.push_back(mk_cmd(CMD_INJECT, 20, 20, 49, 0));
    pending_cmds.push_back(mk_cmd(CMD_INJECT, 20, 25, -99, 0));
    pending_cmds.push_back(mk_cmd(CMD_INJECT, 0, 5, 10, 0));
    pending_cmds.push_back(mk_cmd(CMD_INJECT, 119, 5, 10, 0));
    pending_cmds.push_back(mk_cmd(CMD_INJECT, 5, 159, 10, 0));
    pending_cmds.push_back(mk_cmd(CMD_INJECT, 255, 255, -1, 0));
    pending_cmds.push_back(mk_cmd(CMD_READ, 119, 159, 0, 0));
    pending_cmds.push_back(mk_cmd(CMD_READ, 120, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(CMD_READ, 0, 160, 0, 0));
    pending_cmds.push_back(mk_cmd(CMD_READ, 1, 2, 0, 0));
    pending_cmds.push_back(mk_cmd(CMD_STEP, 0, 0, 0, 256));
    pending_cmds.push_back(mk_cmd(CMD_READ, 60, 81, 0, 0));
    pending_cmds.push_back(mk_cmd(CMD_STEP, 255, 255, -1, 511));
    pending_cmds.push_back(mk_cmd(CMD_READ, 61, 80, 0, 0));
    pending_cmds.push_back(mk_cmd(CMD_STEP, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(CMD_READ, 2, 2, 0, 0));
    pending_cmds.push_back(mk_cmd(CMD_CLEAR, 255, 255, -1, 511));
    pending_cmds.push_back(mk_cmd(CMD_READ, 60, 80, 0, 0));
    // random: steps are costly, so they stay rare; reads cluster near sources
    for (int i = 0; i < 100; i++) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        pending_cmds.push_back(mk_cmd(CMD_CLEAR, $urandom_range(255), $urandom_range(255),
                                      $urandom_range(255), $urandom_range(511)));
      end else if (pick < 11) begin
        pending_cmds.push_back(mk_cmd(CMD_STEP, $urandom_range(255), $urandom_range(255),
                                      $urandom_range(255),
                                      ($urandom_range(3) == 0) ? $urandom_range(511)
                                                               : $urandom_range(256, 200)));
      end else if (pick < 45) begin
        if ($urandom_range(9) == 0) begin
          r0 = $urandom_range(255);
          c0 = $urandom_range(255);
        end else begin
          r0 = $urandom_range(ROWS - 2, 1);
          c0 = $urandom_range(COLS - 2, 1);
          hot_r = r0;
          hot_c = c0;
        end
        pending_cmds.push_back(mk_cmd(CMD_INJECT, r0, c0, $urandom_range(255),
                                      $urandom_range(511)));
      end else begin
        pick = $urandom_range(9);
        if (pick < 6) begin
          r0 = hot_r + $urandom_range(6) - 3;
          c0 = hot_c + $urandom_range(6) - 3;
        end else if (pick < 8) begin
          r0 = $urandom_range(ROWS - 1);
          c0 = $urandom_range(COLS - 1);
        end else begin
          r0 = $urandom_range(255);
          c0 = $urandom_range(255);
        end
        pending_cmds.push_back(mk_cmd(CMD_READ, r0, c0, $urandom_range(255),
                                      $urandom_range(511)));
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pending_cmds.size() > 0 || in_valid || expected_cells.size() > 0);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && expected_cells.size() == 0)
      $display("damped_wave_grid_engine_top regression: pass");
    else
      $display("damped_wave_grid_engine_top regression: fail");
    $finish;
  end
endmodule
